// ===== design/rms_pkg.sv =====
// Shared constants and beat types for the range-minimum sparse table engine.
package rms_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int LEVELS       = 11;
  localparam int VALUE_WIDTH  = 32;

  localparam int IDX_W   = 10;               // position within one level
  localparam int CNT_W   = IDX_W + 1;        // holds MAX_ELEMENTS itself
  localparam int LVL_W   = 4;                // level number
  localparam int SPAN_W  = CNT_W + 1;        // window length with headroom
  localparam int ADDR_W  = LVL_W + IDX_W;
  localparam int MEM_DEPTH = LEVELS * MAX_ELEMENTS;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic                          action;
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          last_element;
    logic        [IDX_W-1:0]       left;
    logic        [IDX_W-1:0]       right;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] minimum;
    logic                          range_error;
  } out_item_t;

endpackage

// ===== design/range_min_sparse_table_top.sv =====
// Range-minimum engine: sparse table in one memory, load, build and query control.
//
// Usage. An input beat is taken at a rising edge where start is high and busy
// is low. A load beat (action 0) writes the next element of level zero and
// gives no result; loads can follow every cycle. The load beat with
// last_element set ends the array and, if it holds at least two elements, starts
// the build, during which busy stays high. Each written entry takes one memory read
// of two level entries, then one write of their minimum; level j >= 1 gets
// count - 2^j + 1 entries, and the single table memory keeps read and write apart.
// A query beat (action 1) reads two entries of one level in the cycle it is
// taken; the result appears in the next cycle, for exactly one cycle, marked by
// out_strobe. Queries can be issued every cycle, one result per query.
// A query with no closed array or with a bad range (left > right, or right not below
// the element count) returns range_error set and a minimum of zero.
// A load after a build starts a new array. Reset clears the element count and
// the built flag; the table memory itself is not cleared. The receiver cannot
// stall, so results are never held back.
module range_min_sparse_table_top
  import rms_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);

  typedef enum logic [1:0] {ST_IDLE, ST_BLD_RD, ST_BLD_WR} state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              ready_r, ready_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              strobe_r, strobe_nxt;
  logic              qerr_r, qerr_nxt;

  // Table memory: one write port, two registered read ports.
  logic signed [VALUE_WIDTH-1:0] table_mem [MEM_DEPTH];
  logic signed [VALUE_WIDTH-1:0] rd_a_r, rd_b_r;
  logic [ADDR_W-1:0]             rd_a_addr, rd_b_addr, wr_addr;
  logic signed [VALUE_WIDTH-1:0] wr_data;
  logic                          wr_en;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  logic signed [VALUE_WIDTH-1:0] pair_min;
  assign pair_min = (rd_a_r <= rd_b_r) ? rd_a_r : rd_b_r;

  // Query address generation.
  logic [CNT_W-1:0]  q_len;
  logic [LVL_W-1:0]  q_k;
  logic [CNT_W-1:0]  q_start;
  logic              q_bad;

  always_comb begin
    q_len = CNT_W'(in_item.right) - CNT_W'(in_item.left) + CNT_W'(1);
    q_k   = '0;
    for (int b = 1; b < CNT_W; b++) begin
      if (q_len[b]) begin
        q_k = LVL_W'(b);
      end
    end
    if (q_k > LVL_W'(LEVELS - 1)) begin
      q_k = LVL_W'(LEVELS - 1);
    end
    q_start = CNT_W'(in_item.right) + CNT_W'(1) - (CNT_W'(1) << q_k);
    q_bad   = !ready_r || (in_item.left > in_item.right) ||
              (CNT_W'(in_item.right) >= count_r);
  end

  // Build step geometry.
  logic [SPAN_W-1:0] span, half, next_end, next_span;
  logic [LVL_W-1:0]  lvl_below;
  logic [IDX_W-1:0]  idx_hi;

  always_comb begin
    span      = SPAN_W'(1) << lvl_r;
    half      = span >> 1;
    next_span = span << 1;
    next_end  = SPAN_W'(idx_r) + span + SPAN_W'(1);
    lvl_below = lvl_r - LVL_W'(1);
    idx_hi    = idx_r + IDX_W'(half);
  end

  always_comb begin
    if (state_r == ST_BLD_RD) begin
      rd_a_addr = {lvl_below, idx_r};
      rd_b_addr = {lvl_below, idx_hi};
    end else begin
      rd_a_addr = {q_k, in_item.left};
      rd_b_addr = {q_k, q_start[IDX_W-1:0]};
    end
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    ready_nxt  = ready_r;
    lvl_nxt    = lvl_r;
    idx_nxt    = idx_r;
    strobe_nxt = 1'b0;
    qerr_nxt   = qerr_r;
    wr_en      = 1'b0;
    wr_addr    = {LVL_W'(0), count_r[IDX_W-1:0]};
    wr_data    = in_item.value;

    case (state_r)
      ST_IDLE: begin
        if (accept && in_item.action == ACT_QUERY) begin
          strobe_nxt = 1'b1;
          qerr_nxt   = q_bad;
        end else if (accept) begin
          // A load after a build starts a new array at position zero.
          count_nxt = ready_r ? '0 : count_r;
          ready_nxt = 1'b0;
          wr_addr   = {LVL_W'(0), count_nxt[IDX_W-1:0]};
          if (count_nxt < CNT_W'(MAX_ELEMENTS)) begin
            wr_en     = 1'b1;
            count_nxt = count_nxt + CNT_W'(1);
          end
          if (in_item.last_element) begin
            lvl_nxt = LVL_W'(1);
            idx_nxt = '0;
            if (count_nxt >= CNT_W'(2)) begin
              state_nxt = ST_BLD_RD;
            end else begin
              ready_nxt = 1'b1;
            end
          end
        end
      end
      ST_BLD_RD: begin
        state_nxt = ST_BLD_WR;
      end
      ST_BLD_WR: begin
        wr_en   = 1'b1;
        wr_addr = {lvl_r, idx_r};
        wr_data = pair_min;
        if (next_end <= SPAN_W'(count_r)) begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = ST_BLD_RD;
        end else if ((lvl_r < LVL_W'(LEVELS - 1)) && (next_span <= SPAN_W'(count_r))) begin
          lvl_nxt   = lvl_r + LVL_W'(1);
          idx_nxt   = '0;
          state_nxt = ST_BLD_RD;
        end else begin
          ready_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      ready_r  <= 1'b0;
      strobe_r <= 1'b0;
      lvl_r    <= '0;
      idx_r    <= '0;
      qerr_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ready_r  <= ready_nxt;
      strobe_r <= strobe_nxt;
      lvl_r    <= lvl_nxt;
      idx_r    <= idx_nxt;
      qerr_r   <= qerr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    rd_a_r <= table_mem[rd_a_addr];
    rd_b_r <= table_mem[rd_b_addr];
  end

  assign out_strobe           = strobe_r;
  assign out_item.range_error = qerr_r;
  assign out_item.minimum     = qerr_r ? '0 : pair_min;

endmodule

// ===== test/rms_min_checker.sv =====
// Checker that watches the engine's beats, predicts each range minimum and compares results.
`timescale 1ns / 100ps

module rms_min_checker
  import rms_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_strobe,
  input  out_item_t out_item,
  output int        fail_count,
  output int        pending
);

  typedef logic signed [VALUE_WIDTH-1:0] elem_t;

  // span_min[j][i] is the minimum of the 2^j elements that start at position i.
  elem_t     span_min [LEVELS][MAX_ELEMENTS];
  int        held;
  bit        built;
  out_item_t awaited_minima [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    held       = 0;
    built      = 1'b0;
  end

  function automatic elem_t lesser(elem_t a, elem_t b);
    return (a <= b) ? a : b;
  endfunction

  task automatic build_levels();
    for (int j = 1; j < LEVELS && (1 << j) <= held; j++) begin
      for (int i = 0; i + (1 << j) <= held; i++) begin
        span_min[j][i] = lesser(span_min[j-1][i], span_min[j-1][i + (1 << (j-1))]);
      end
    end
    built = 1'b1;
  endtask

  task automatic take_load(elem_t v, logic last);
    // A load that follows a build starts a new array.
    if (built) begin
      built = 1'b0;
      held  = 0;
    end
    // Once the array is full, further values are dropped, but the last flag still builds.
    if (held < MAX_ELEMENTS) begin
      span_min[0][held] = v;
      held++;
    end
    if (last) build_levels();
  endtask

  function automatic out_item_t range_minimum(int l, int r);
    out_item_t res;
    int        len;
    int        k;
    res             = '0;
    res.range_error = 1'b1;
    if (!built || l > r || r >= held) return res;
    len = r - l + 1;
    k   = 0;
    while ((len >> (k + 1)) != 0) k++;
    if (k > LEVELS - 1) k = LEVELS - 1;
    // Two windows of length 2^k, one anchored at left and one ending at right.
    res.range_error = 1'b0;
    res.minimum     = lesser(span_min[k][l], span_min[k][r + 1 - (1 << k)]);
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      held  = 0;
      built = 1'b0;
      awaited_minima.delete();
    end else begin
      if (out_strobe === 1'b1) begin
        if (awaited_minima.size() == 0) begin
          $display("%0t: result beat with no query waiting: minimum %0d, range_error %0b",
                   $time, out_item.minimum, out_item.range_error);
          fail_count++;
        end else begin
          want = awaited_minima.pop_front();
          if (out_item.minimum !== want.minimum) begin
            $display("%0t: minimum mismatch, expected %0d, actual %0d",
                     $time, want.minimum, out_item.minimum);
            fail_count++;
          end
          if (out_item.range_error !== want.range_error) begin
            $display("%0t: range_error mismatch, expected %0b, actual %0b",
                     $time, want.range_error, out_item.range_error);
            fail_count++;
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        if (in_item.action == ACT_LOAD) begin
          take_load(in_item.value, in_item.last_element);
        end else begin
          awaited_minima.push_back(range_minimum(in_item.left, in_item.right));
        end
      end
    end
    pending = awaited_minima.size();
  end

endmodule

// ===== test/tb_top.sv =====
// Top of the testbench: clock, reset, load and query stimulus, and the final verdict.
`timescale 1ns / 100ps

module tb_top;
  import rms_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_strobe;
  out_item_t out_item;
  int        fail_count;
  int        pending;

  // Shadow of the element count and build flag, used only to aim queries at valid ranges.
  int        held;
  bit        built;
  int        beats_sent;
  bit        idling;
  int        quiet;
  int        n;

  range_min_sparse_table_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  rms_min_checker min_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic pause_sender(int cycles);
    @(negedge clk);
    start = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic issue(in_item_t beat);
    // Gaps come in bursts, separated by stretches where the sender never pauses.
    if (idling) begin
      if (quiet == 0 && $urandom_range(0, 4) == 0) begin
        pause_sender($urandom_range(1, 12));
        quiet = $urandom_range(0, 40);
      end else if (quiet > 0) begin
        quiet--;
      end
    end
    @(negedge clk);
    start   = 1'b1;
    in_item = beat;
    do @(posedge clk); while (busy !== 1'b0);
    beats_sent++;
  endtask

  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    case ($urandom_range(0, 15))
      0:             v = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      1, 2, 3, 4:    v = $signed($urandom_range(0, 16)) - 8;
      default:       v = $urandom;
    endcase
    return v;
  endfunction

  task automatic load_elem(logic signed [31:0] v, logic last);
    in_item_t b;
    b.action       = ACT_LOAD;
    b.value        = v;
    b.last_element = last;
    b.left         = IDX_W'($urandom);
    b.right        = IDX_W'($urandom);
    if (built) begin
      built = 1'b0;
      held  = 0;
    end
    if (held < MAX_ELEMENTS) held++;
    if (last) built = 1'b1;
    issue(b);
  endtask

  task automatic ask_range(int l, int r);
    in_item_t b;
    b.action       = ACT_QUERY;
    b.value        = $urandom;
    b.last_element = 1'($urandom);
    b.left         = IDX_W'(l);
    b.right        = IDX_W'(r);
    issue(b);
  endtask

  task automatic ask_some_range();
    int l;
    int r;
    l = $urandom_range(0, 1023);
    r = $urandom_range(0, 1023);
    if (built) begin
      case ($urandom_range(0, 9))
        0: if (held < MAX_ELEMENTS) begin
          r = held;
          l = $urandom_range(0, r);
        end
        1: if (held > 1) begin
          l = $urandom_range(1, held - 1);
          r = $urandom_range(0, l - 1);
        end
        2: ;
        default: begin
          l = $urandom_range(0, held - 1);
          r = $urandom_range(l, held - 1);
        end
      endcase
    end
    ask_range(l, r);
  endtask

  task automatic fill_array(int count, bit close_it);
    for (int i = 0; i < count; i++) begin
      // Now and then a query lands in the middle of a load and must be refused.
      if (i > 0 && $urandom_range(0, 9) == 0) ask_some_range();
      load_elem(pick_value(), close_it && i == count - 1);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_item    = '0;
    held       = 0;
    built      = 1'b0;
    beats_sent = 0;
    idling     = 1'b0;
    quiet      = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Queries before any table exists.
    ask_range(0, 0);
    ask_range(1023, 1023);
    // Extreme values, built into a five element table.
    load_elem(32'sh7FFF_FFFF, 1'b0);
    load_elem(32'sh8000_0000, 1'b0);
    load_elem(0, 1'b0);
    load_elem(-1, 1'b0);
    load_elem(1, 1'b1);
    ask_range(0, 4);
    ask_range(0, 0);
    ask_range(2, 4);
    ask_range(4, 4);
    ask_range(3, 1);
    ask_range(0, 5);
    ask_range(0, 1023);
    // A load after a build starts over with a one element table.
    load_elem(-5, 1'b1);
    ask_range(0, 0);
    ask_range(0, 1);
    load_elem(3, 1'b0);
    ask_range(0, 0);
    load_elem(-2, 1'b1);
    ask_range(0, 1);
    ask_range(1, 1);
    drain_results();

    idling = 1'b1;
    while (beats_sent < 220) begin
      case ($urandom_range(0, 9))
        0:       n = 1;
        1:       n = 1 << $urandom_range(1, 6);
        2:       n = (1 << $urandom_range(1, 6)) + 1;
        3:       n = ($urandom_range(0, 4) == 0) ? 128 : 31;
        default: n = $urandom_range(2, 24);
      endcase
      fill_array(n, $urandom_range(0, 9) != 0);
      repeat ($urandom_range(3, 16)) ask_some_range();
      if ($urandom_range(0, 5) == 0) drain_results();
    end
    drain_results();

    // A wide array, so that the upper levels of the table are built and queried.
    for (int i = 0; i < 257; i++) begin
      load_elem(pick_value(), i == 256);
    end

    idling = 1'b0;
    ask_range(0, held - 1);
    ask_range(held - 1, held - 1);
    ask_range(0, 0);
    ask_range(127, 128);
    ask_range(1023, 0);
    repeat (90) ask_some_range();
    drain_results();
    repeat (20) @(negedge clk);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
